// ===== rtl/rfrs_pkg.sv =====
// shared types and constants for the region fill ratio stats unit
`default_nettype none
package rfrs_pkg;

  localparam int unsigned NumRegions   = 4096;
  localparam int unsigned LabelW       = 12;
  localparam int unsigned CountW       = 31;
  localparam int unsigned CoordW       = 10;
  localparam int unsigned SizeW        = 11;
  localparam int unsigned FracBits     = 16;
  localparam int unsigned FillW        = FracBits + 1;
  localparam int unsigned PosW         = 30;
  localparam int unsigned BoxW         = 3 * SizeW;
  localparam int unsigned DividendW    = CountW + FracBits;
  localparam logic [SizeW-1:0] MaxDim  = 11'd1024;
  localparam logic [CountW-1:0] CountLimit = 31'h4000_0000;

  localparam logic [1:0] OpClear   = 2'd0;
  localparam logic [1:0] OpVoxel   = 2'd1;
  localparam logic [1:0] OpQuery   = 2'd2;
  localparam logic [1:0] OpIgnored = 2'd3;

  localparam logic [1:0] RegXSize = 2'd0;
  localparam logic [1:0] RegYSize = 2'd1;
  localparam logic [1:0] RegZSize = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [LabelW-1:0] region_label;
  } in_beat_t;

  typedef struct packed {
    logic [LabelW-1:0] queried_label;
    logic [CountW-1:0] cell_count;
    logic [FillW-1:0]  fill_fraction;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic clr_step;   // clear one table row at clr address
    logic clr_pos;    // zero raster position
    logic voxel;      // write back the updated row, advance position
    logic load_q;     // capture label, read its table row
    logic box_mul1;   // first box product
    logic box_mul2;   // second box product
    logic div_start;  // start divider
    logic div_step;   // one quotient bit
    logic out_load;   // load output register
    logic pos_div;    // start position / x_size
    logic pos_div2;   // take x, start quotient / y_size
    logic pos_fin;    // take y and z, or wrap if past the grid
  } rfrs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic empty;
    logic stale;
  } rfrs_sts_t;

endpackage
`default_nettype wire

// ===== rtl/rfrs_datapath.sv =====
// tables, raster position, box product and serial divider
`default_nettype none
module rfrs_datapath
  import rfrs_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire rfrs_cmd_t           cmd_i,
  input  wire in_beat_t            in_beat_i,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [SizeW-1:0]    cfg_data_i,
  output rfrs_sts_t                sts_o,
  output out_beat_t                out_beat_o
);

  localparam int unsigned EntryW = CountW + 6 * CoordW;
  localparam int unsigned CntW   = $clog2(DividendW + 1);

  typedef struct packed {
    logic [CountW-1:0] cnt;
    logic [CoordW-1:0] min_x, max_x, min_y, max_y, min_z, max_z;
  } entry_t;

  localparam entry_t EmptyEntry = '{cnt: '0, min_x: '1, max_x: '0, min_y: '1,
                                    max_y: '0, min_z: '1, max_z: '0};

  logic [EntryW-1:0] mem_q [NumRegions];
  entry_t            rd_q;

  logic [SizeW-1:0]  xs_q, ys_q, zs_q;
  logic [CoordW-1:0] x_q, y_q, z_q;
  logic [PosW-1:0]   pos_q;
  logic              stale_q;
  logic [LabelW-1:0] clr_addr_q, lab_q;
  logic [SizeW-1:0]  ex_q, ey_q, ez_q;
  logic [2*SizeW-1:0] pxy_q;
  logic [BoxW-1:0]   box_q;
  logic [DividendW-1:0] quo_q;
  logic [BoxW:0]     rem_q;
  logic [CntW-1:0]   dcnt_q;
  out_beat_t         out_q;

  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v);
    if (v == '0) return SizeW'(1);
    if (v > MaxDim) return MaxDim;
    return v;
  endfunction

  function automatic logic [SizeW-1:0] extent(input logic [CoordW-1:0] lo,
                                              input logic [CoordW-1:0] hi);
    if (hi >= lo) return SizeW'({1'b0, hi} - {1'b0, lo}) + SizeW'(1);
    return SizeW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xs_q <= SizeW'(1);
      ys_q <= SizeW'(1);
      zs_q <= SizeW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegXSize: xs_q <= clamp_size(cfg_data_i);
        RegYSize: ys_q <= clamp_size(cfg_data_i);
        RegZSize: zs_q <= clamp_size(cfg_data_i);
        default: ;
      endcase
    end
  end

  // a size write leaves x/y/z out of step with the linear position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stale_q <= 1'b0;
    end else if (cfg_we_i) begin
      stale_q <= 1'b1;
    end else if (cmd_i.clr_pos || cmd_i.pos_fin) begin
      stale_q <= 1'b0;
    end
  end

  // raster position kept both linear and as x/y/z counters; after a size
  // write the counters are split again from the linear position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= '0;
      y_q   <= '0;
      z_q   <= '0;
      pos_q <= '0;
    end else if (cmd_i.clr_pos) begin
      x_q   <= '0;
      y_q   <= '0;
      z_q   <= '0;
      pos_q <= '0;
    end else if (cmd_i.pos_div2) begin
      x_q <= CoordW'(rem_q);
    end else if (cmd_i.pos_fin) begin
      if (quo_q >= DividendW'(zs_q)) begin
        // position past the last cell of the new grid wraps to zero
        x_q   <= '0;
        y_q   <= '0;
        z_q   <= '0;
        pos_q <= '0;
      end else begin
        y_q <= CoordW'(rem_q);
        z_q <= CoordW'(quo_q);
      end
    end else if (cmd_i.voxel) begin
      if ({1'b0, x_q} + SizeW'(1) < xs_q) begin
        x_q   <= x_q + CoordW'(1);
        pos_q <= pos_q + PosW'(1);
      end else begin
        x_q <= '0;
        if ({1'b0, y_q} + SizeW'(1) < ys_q) begin
          y_q   <= y_q + CoordW'(1);
          pos_q <= pos_q + PosW'(1);
        end else begin
          y_q <= '0;
          if ({1'b0, z_q} + SizeW'(1) < zs_q) begin
            z_q   <= z_q + CoordW'(1);
            pos_q <= pos_q + PosW'(1);
          end else begin
            z_q   <= '0;
            pos_q <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_addr_q <= clr_addr_q + LabelW'(1);
    end
  end

  // voxel update: row read at accept into rd_q, written back in the voxel state
  entry_t upd;
  always_comb begin
    upd = rd_q;
    if (rd_q.cnt < CountLimit) upd.cnt = rd_q.cnt + CountW'(1);
    if (x_q < rd_q.min_x) upd.min_x = x_q;
    if (x_q > rd_q.max_x) upd.max_x = x_q;
    if (y_q < rd_q.min_y) upd.min_y = y_q;
    if (y_q > rd_q.max_y) upd.max_y = y_q;
    if (z_q < rd_q.min_z) upd.min_z = z_q;
    if (z_q > rd_q.max_z) upd.max_z = z_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      mem_q[clr_addr_q] <= EmptyEntry;
    end else if (cmd_i.voxel) begin
      mem_q[lab_q] <= upd;
    end
    if (cmd_i.load_q) begin
      rd_q  <= entry_t'(mem_q[in_beat_i.region_label]);
      lab_q <= in_beat_i.region_label;
    end
  end

  // box product over two multiply steps, then restoring divide; the same
  // divider splits the linear position by x_size and then by y_size
  always_ff @(posedge clk_i) begin
    if (cmd_i.box_mul1) begin
      ex_q  <= extent(rd_q.min_x, rd_q.max_x);
      ey_q  <= extent(rd_q.min_y, rd_q.max_y);
      ez_q  <= extent(rd_q.min_z, rd_q.max_z);
    end
    if (cmd_i.box_mul2) begin
      pxy_q <= ex_q * ey_q;
    end
    if (cmd_i.div_start) begin
      box_q <= BoxW'(pxy_q) * BoxW'(ez_q);
      quo_q <= {rd_q.cnt, FracBits'(0)};
      rem_q <= '0;
    end else if (cmd_i.pos_div) begin
      box_q <= BoxW'(xs_q);
      quo_q <= DividendW'(pos_q);
      rem_q <= '0;
    end else if (cmd_i.pos_div2) begin
      box_q <= BoxW'(ys_q);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      logic [BoxW:0] trial;
      trial = {rem_q[BoxW-1:0], quo_q[DividendW-1]};
      if (trial >= {1'b0, box_q}) begin
        rem_q <= trial - {1'b0, box_q};
        quo_q <= {quo_q[DividendW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[DividendW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start || cmd_i.pos_div || cmd_i.pos_div2) begin
      dcnt_q <= CntW'(DividendW - 1);
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q - CntW'(1);
    end
  end

  assign sts_o = '{clr_last: (clr_addr_q == '1),
                   div_last: (dcnt_q == '0),
                   empty:    (rd_q.cnt == '0),
                   stale:    stale_q};

  localparam logic [DividendW-1:0] One = DividendW'(1) << FracBits;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.queried_label <= lab_q;
      out_q.cell_count    <= rd_q.cnt;
      if (rd_q.cnt == '0) out_q.fill_fraction <= '0;
      else if (quo_q > One) out_q.fill_fraction <= FillW'(One);
      else out_q.fill_fraction <= FillW'(quo_q);
    end
  end
  assign out_beat_o = out_q;

endmodule
`default_nettype wire

// ===== rtl/rfrs_ctrl.sv =====
// controller state machine for beat handling, clear sweep and divide
`default_nettype none
module rfrs_ctrl
  import rfrs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] in_op_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire rfrs_sts_t  sts_i,
  output rfrs_cmd_t       cmd_o
);

  localparam logic [3:0] StClear  = 4'd0;
  localparam logic [3:0] StIdle   = 4'd1;
  localparam logic [3:0] StMul1   = 4'd2;
  localparam logic [3:0] StMul2   = 4'd3;
  localparam logic [3:0] StDivS   = 4'd4;
  localparam logic [3:0] StDiv    = 4'd5;
  localparam logic [3:0] StOut    = 4'd6;
  localparam logic [3:0] StVox    = 4'd7;
  localparam logic [3:0] StPDivX  = 4'd8;
  localparam logic [3:0] StPLoadY = 4'd9;
  localparam logic [3:0] StPDivY  = 4'd10;
  localparam logic [3:0] StPFin   = 4'd11;

  logic [3:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic       acc;

  // input waits while busy; a query also waits while the previous result is still held
  assign in_stall_o  = (state_q != StIdle) || (ovalid_q && in_op_i == OpQuery);
  assign acc         = in_valid_i && !in_stall_o;
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q && out_stall_i;
    cmd_o    = '0;
    unique case (state_q)
      StClear: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = StIdle;
      end
      StIdle: begin
        if (acc) begin
          case (in_op_i)
            OpClear: begin
              cmd_o.clr_pos = 1'b1;
              state_d = StClear;
            end
            OpVoxel: begin
              cmd_o.load_q = 1'b1;
              if (sts_i.stale) begin
                cmd_o.pos_div = 1'b1;
                state_d = StPDivX;
              end else begin
                state_d = StVox;
              end
            end
            OpQuery: begin
              cmd_o.load_q = 1'b1;
              state_d = StMul1;
            end
            default: ;
          endcase
        end
      end
      StMul1: begin
        cmd_o.box_mul1 = 1'b1;
        state_d = StMul2;
      end
      StMul2: begin
        cmd_o.box_mul2 = 1'b1;
        state_d = StDivS;
      end
      StDivS: begin
        cmd_o.div_start = 1'b1;
        state_d = sts_i.empty ? StOut : StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = StOut;
      end
      StOut: begin
        cmd_o.out_load = 1'b1;
        ovalid_d = 1'b1;
        state_d = StIdle;
      end
      StVox: begin
        cmd_o.voxel = 1'b1;
        state_d = StIdle;
      end
      StPDivX: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = StPLoadY;
      end
      StPLoadY: begin
        cmd_o.pos_div2 = 1'b1;
        state_d = StPDivY;
      end
      StPDivY: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = StPFin;
      end
      StPFin: begin
        cmd_o.pos_fin = 1'b1;
        state_d = StVox;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClear;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/region_fill_ratio_stats_unit.sv =====
// top level of the region fill ratio stats unit
// voxel beat: row read, then write back; the first after a size write first splits the position by x_size and y_size
// query: extents, box product, 47-step divider, then output register; an empty region skips the divider
// clear beat: sweep of all 4096 rows of the label table, input stalled meanwhile
// after reset the same clearing sweep runs before any beat is taken
// a pending result never blocks voxel beats; only a new query waits for it
`default_nettype none
module region_fill_ratio_stats_unit
  import rfrs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_beat_t         in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_beat_t             out_data_o,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [SizeW-1:0] cfg_data_i
);

  rfrs_cmd_t cmd;
  rfrs_sts_t sts;

  // sequencing of beats, clear sweep and divide
  rfrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_data_i.op),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // label table, raster position and fill ratio arithmetic
  rfrs_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_beat_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sts_o      (sts),
    .out_beat_o (out_data_o)
  );

endmodule
`default_nettype wire
